// ===== design/four_lane_interleaved_bit_packer_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the four-lane bit packer
// Each macro expands to a labeled concurrent assertion, or to nothing.
// ----------------------------------------------------------------------------
`ifndef FOUR_LANE_INTERLEAVED_BIT_PACKER_DEFINES_SVH
`define FOUR_LANE_INTERLEAVED_BIT_PACKER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define FLIBP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flibp assertion failed");

// Next-cycle implication.
`define FLIBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flibp assertion failed");

`else

`define FLIBP_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define FLIBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/flibp_pkg.sv =====
// ----------------------------------------------------------------------------
// flibp_pkg
// Shared constants and the operation record passed from front to back.
// ----------------------------------------------------------------------------
package flibp_pkg;

    localparam int LANES                = 4;
    localparam int WORD_BITS            = 32;
    localparam int WIDTH_BITS           = 6;
    localparam int OFFSET_BITS          = 5;
    localparam int BLOCK_GROUPS_DEFAULT = 32;
    localparam int QUEUE_DEPTH_DEFAULT  = 2;

    // One classified group: masked lane values plus everything the back end
    // needs to merge them into the accumulators.
    typedef struct packed {
        logic [LANES-1:0][WORD_BITS-1:0] value;
        logic [OFFSET_BITS-1:0]          offset;
        logic                            emit;
        logic                            last;
        logic                            carry_en;
        logic [OFFSET_BITS-1:0]          carry_shift;
    } op_t;

endpackage

// ===== design/flibp_front.sv =====
// ----------------------------------------------------------------------------
// flibp_front
// Accepts groups, masks the lane values and works out offset, emit, last and carry.
// ----------------------------------------------------------------------------
`include "four_lane_interleaved_bit_packer_defines.svh"

module flibp_front #(
    parameter int BLOCK_GROUPS = flibp_pkg::BLOCK_GROUPS_DEFAULT
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [flibp_pkg::WIDTH_BITS-1:0]           cfg_wdata,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [flibp_pkg::LANES*flibp_pkg::WORD_BITS-1:0] s_tdata,
    input  logic                                       queue_ready,
    output logic                                       push,
    output flibp_pkg::op_t                             push_op
);
    import flibp_pkg::*;

    localparam int GROUP_BITS = (BLOCK_GROUPS > 1) ? $clog2(BLOCK_GROUPS) : 1;

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [GROUP_BITS-1:0]  group_reg, group_next;

    logic [WIDTH_BITS-1:0]  width_sat;
    logic [WORD_BITS-1:0]   mask;
    logic [WIDTH_BITS-1:0]  sum;
    logic                   accept;
    logic                   width_zero;

    assign s_tready   = queue_ready;
    assign accept     = s_tvalid && s_tready;

    // Widths above a full word saturate to a full word.
    assign width_sat  = (width_reg > WIDTH_BITS'(WORD_BITS)) ? WIDTH_BITS'(WORD_BITS)
                                                              : width_reg;
    assign width_zero = (width_sat == '0);
    assign mask       = {WORD_BITS{1'b1}} >> (WIDTH_BITS'(WORD_BITS) - width_sat);
    assign sum        = WIDTH_BITS'(offset_reg) + width_sat;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            push_op.value[k] = s_tdata[k*WORD_BITS +: WORD_BITS] & mask;
        end
        push_op.offset      = offset_reg;
        push_op.emit        = sum[WIDTH_BITS-1];
        push_op.last        = (group_reg == GROUP_BITS'(BLOCK_GROUPS - 1));
        push_op.carry_en    = (sum[OFFSET_BITS-1:0] != '0);
        push_op.carry_shift = width_sat[OFFSET_BITS-1:0] - sum[OFFSET_BITS-1:0];
    end

    // A zero width keeps the block framing but produces no work.
    assign push = accept && !width_zero;

    always_comb
    begin
        offset_next = offset_reg;
        group_next  = group_reg;
        if (accept)
        begin
            group_next = push_op.last ? '0 : group_reg + GROUP_BITS'(1);
            if (!width_zero)
            begin
                offset_next = sum[OFFSET_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            offset_reg <= '0;
            group_reg  <= '0;
        end
        else if (cfg_we)
        begin
            width_reg  <= cfg_wdata;
            offset_reg <= '0;
            group_reg  <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
            group_reg  <= group_next;
        end
    end

    `FLIBP_ASSERT_SAME(a_zero_width_no_push, clk, rst_n, accept && width_zero, !push)

endmodule

// ===== design/flibp_queue.sv =====
// ----------------------------------------------------------------------------
// flibp_queue
// Short first-in first-out queue of classified groups between front and back.
// ----------------------------------------------------------------------------
`include "four_lane_interleaved_bit_packer_defines.svh"

module flibp_queue #(
    parameter int DEPTH = flibp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  flibp_pkg::op_t push_op,
    output logic           ready,
    output logic           head_valid,
    output flibp_pkg::op_t head_op,
    input  logic           pop
);
    import flibp_pkg::*;

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    op_t                   entry_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    assign ready      = (count_reg != COUNT_BITS'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    `FLIBP_ASSERT_SAME(a_no_push_when_full, clk, rst_n, push, ready)
    `FLIBP_ASSERT_SAME(a_no_pop_when_empty, clk, rst_n, pop, head_valid)

endmodule

// ===== design/flibp_back.sv =====
// ----------------------------------------------------------------------------
// flibp_back
// Merges classified groups into the lane accumulators and emits full chunks.
// ----------------------------------------------------------------------------
`include "four_lane_interleaved_bit_packer_defines.svh"

module flibp_back (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic                                       head_valid,
    input  flibp_pkg::op_t                             head_op,
    output logic                                       pop,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [flibp_pkg::LANES*flibp_pkg::WORD_BITS-1:0] m_tdata,
    output logic                                       m_tlast
);
    import flibp_pkg::*;

    logic [LANES-1:0][WORD_BITS-1:0] acc_reg, acc_next;
    logic [LANES-1:0][WORD_BITS-1:0] merged;
    logic [LANES-1:0][WORD_BITS-1:0] data_reg;
    logic                            last_reg;
    logic                            out_valid_reg, out_valid_next;

    // An emitting group needs the output register free, or freed this cycle.
    assign pop = head_valid && (!head_op.emit || !out_valid_reg || m_tready);

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (head_op.offset == '0)
            begin
                merged[k] = head_op.value[k];
            end
            else
            begin
                merged[k] = acc_reg[k] | (head_op.value[k] << head_op.offset);
            end
        end
    end

    always_comb
    begin
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (pop)
        begin
            if (head_op.emit)
            begin
                out_valid_next = 1'b1;
                for (int k = 0; k < LANES; k++)
                begin
                    acc_next[k] = head_op.carry_en ? (head_op.value[k] >> head_op.carry_shift)
                                                   : '0;
                end
            end
            else
            begin
                acc_next = merged;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= cfg_we ? '0 : acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_op.emit)
        begin
            data_reg <= merged;
            last_reg <= head_op.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = data_reg;

    `FLIBP_ASSERT_NEXT(a_emit_fills_output, clk, rst_n, pop && head_op.emit, out_valid_reg)
    `FLIBP_ASSERT_NEXT(a_no_carry_clears_acc, clk, rst_n,
        pop && head_op.emit && !head_op.carry_en && !cfg_we, acc_reg == '0)

endmodule

// ===== design/four_lane_interleaved_bit_packer.sv =====
// A group accepted at a clock edge enters the queue at that edge; the back end later pops it
// and, if the group emits, registers its chunk in the output register behind m_tvalid.
// Throughput: one group per cycle while the queue has room; at most one chunk leaves per cycle.
// The queue (two entries by default) between front and back end absorbs output stalls.
// Reset (rst_n, asynchronous, active low) clears width, offset, group count and accumulators.
// A bit_width write also restarts the block: offset, group count and accumulators clear.
// ----------------------------------------------------------------------------
// four_lane_interleaved_bit_packer
// Packs four lanes of values at a programmable bit width into 128-bit chunks.
// ----------------------------------------------------------------------------
module four_lane_interleaved_bit_packer #(
    parameter int BLOCK_GROUPS = flibp_pkg::BLOCK_GROUPS_DEFAULT,
    parameter int QUEUE_DEPTH  = flibp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [flibp_pkg::WIDTH_BITS-1:0]            cfg_wdata,  // bit_width
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // lane0_value, lane1_value, lane2_value, lane3_value
    input  logic [flibp_pkg::LANES*flibp_pkg::WORD_BITS-1:0] s_tdata,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // lane0_word, lane1_word, lane2_word, lane3_word
    output logic [flibp_pkg::LANES*flibp_pkg::WORD_BITS-1:0] m_tdata,
    output logic                                        m_tlast     // block_done
);
    import flibp_pkg::*;

    logic queue_ready;
    logic push;
    op_t  push_op;
    logic head_valid;
    op_t  head_op;
    logic pop;

    flibp_front #(
        .BLOCK_GROUPS (BLOCK_GROUPS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .queue_ready (queue_ready),
        .push        (push),
        .push_op     (push_op)
    );

    flibp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .ready      (queue_ready),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop)
    );

    flibp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
